FILE: sv/hash_edge_partitioner_unit_defines.svh
// Assertion helpers used by the checker of the partitioner.
`ifndef HASH_EDGE_PARTITIONER_UNIT_DEFINES_SVH
`define HASH_EDGE_PARTITIONER_UNIT_DEFINES_SVH

// Clocked assertion that is off while reset is low.
`define HEP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define HEP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/hep_pkg.sv
`default_nettype none

package hep_pkg;

  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int VERTEX_COUNT_DEF   = 65536;
  localparam int COUNT_WIDTH_DEF    = 32;

  localparam int VID_W      = 16;
  localparam int HASH_W     = VID_W + 1;
  localparam int PART_CFG_W = 5;
  localparam logic [PART_CFG_W-1:0] PART_RESET = 5'd8;

  // remainder unit: bits consumed per cycle and number of cycles
  localparam int MOD_STEP_BITS = 6;
  localparam int MOD_STEPS     = (HASH_W + MOD_STEP_BITS - 1) / MOD_STEP_BITS;
  localparam int MOD_DIV_W     = MOD_STEPS * MOD_STEP_BITS;

  localparam int BUCKET_W   = 4;
  localparam int OUT_EDGE_W = 32;
  localparam int MIRROR_W   = 21;
  localparam logic [MIRROR_W-1:0]   MIRROR_MAX   = '1;
  localparam logic [OUT_EDGE_W-1:0] OUT_EDGE_MAX = '1;

  typedef enum logic {
    OP_EDGE   = 1'b0,
    OP_REPORT = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [VID_W-1:0]  first_vertex;
    logic [VID_W-1:0]  second_vertex;
  } in_item_t;

  typedef struct packed {
    logic [BUCKET_W-1:0]   bucket;
    logic [OUT_EDGE_W-1:0] largest_bucket_edges;
    logic [MIRROR_W-1:0]   mirror_total;
    logic                  is_report;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } cnt_ctl_t;

endpackage

`default_nettype wire

FILE: sv/hep_mod_unit.sv
`default_nettype none

module hep_mod_unit import hep_pkg::*; #(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [HASH_W-1:0]   dividend,
  input  wire logic [$clog2(MAX_PARTITIONS+1)-1:0] divisor,
  output logic                     done,
  output logic [((MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1)-1:0] rem
);

  localparam int PW = $clog2(MAX_PARTITIONS + 1);
  localparam int BW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CW = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(MOD_STEPS - 1);

  logic                 busy_r;
  logic [CW-1:0]        cnt_r;
  logic [MOD_DIV_W-1:0] div_r;
  logic [PW-1:0]        rem_r;
  logic [PW-1:0]        d_r;
  logic [PW-1:0]        rem_nxt;

  // shift in one dividend bit at a time, subtract when the partial reaches d
  always_comb begin
    logic [PW:0]   t;
    logic [PW-1:0] r;
    r = rem_r;
    for (int i = 0; i < MOD_STEP_BITS; i++) begin
      t = {r, div_r[MOD_DIV_W-1-i]};
      if (t >= {1'b0, d_r}) begin
        t = t - {1'b0, d_r};
      end
      r = t[PW-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= MOD_DIV_W'(dividend);
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      div_r <= div_r << MOD_STEP_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign done = busy_r && (cnt_r == LAST_STEP);
  assign rem  = BW'(rem_nxt);

endmodule

`default_nettype wire

FILE: sv/hep_count_store.sv
`default_nettype none

module hep_count_store import hep_pkg::*; #(
  parameter int DEPTH = MAX_PARTITIONS_DEF,
  parameter int CW    = COUNT_WIDTH_DEF,
  parameter int MW    = $clog2(VERTEX_COUNT_DEF + 1)
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cnt_ctl_t ctl,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [CW-1:0] wr_edges,
  input  wire logic [MW-1:0] wr_marks,
  output logic [CW-1:0] rd_edges,
  output logic [MW-1:0] rd_marks
);

  logic [CW+MW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [CW+MW-1:0] rd_r;

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_edges, wr_marks};
    end
    if (ctl.rd_en) begin
      rd_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_edges = rd_r[CW+MW-1:MW];
  assign rd_marks = rd_r[MW-1:0];

endmodule

`default_nettype wire

FILE: sv/hash_edge_partitioner_unit.sv
// Channel   Dir  Handshake          Payload
// in_       in   in_valid/in_stall   in_item_t  (opcode, first/second vertex)
// out_      out  out_valid/out_stall out_item_t (bucket, largest, mirrors, is_report)
// cfg_      in   cfg_wr_en           cfg_wr_data: partition count
//
// An edge is accepted, passes through the remainder unit, 6 dividend bits a
// step, then does one read-modify-write on the presence memory per endpoint.
// A report does one count read per bucket over P buckets, P the effective
// partition count. After reset a clearing pass zeros every entry of the
// presence memory; in_stall stays high until it ends. A result waits in the
// output register while out_stall is high; the next item is taken meanwhile
// and only its final step holds until the register frees.
`default_nettype none

module hash_edge_partitioner_unit import hep_pkg::*; #(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
  parameter int VERTEX_COUNT   = VERTEX_COUNT_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [PART_CFG_W-1:0] cfg_wr_data
);

  localparam int PW = $clog2(MAX_PARTITIONS + 1);
  localparam int BW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int AW = $clog2(VERTEX_COUNT);
  localparam int MW = $clog2(VERTEX_COUNT + 1);
  localparam int LW = (COUNT_WIDTH > OUT_EDGE_W) ? COUNT_WIDTH : OUT_EDGE_W;
  localparam int SW = ((MW > MIRROR_W) ? MW : MIRROR_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_LO, S_HI, S_RPT, S_RLAST, S_RDONE
  } state_t;

  state_t                  state_r;
  logic [PART_CFG_W-1:0]   cfg_r;
  logic [AW-1:0]           clr_r;
  logic [VID_W-1:0]        lo_r;
  logic [VID_W-1:0]        hi_r;
  logic [BW-1:0]           bkt_r;
  logic                    lo_new_r;
  logic [MAX_PARTITIONS-1:0] lo_mask_r;
  logic [BW-1:0]           idx_r;
  logic                    pend_r;
  logic [COUNT_WIDTH-1:0]  largest_r;
  logic [MIRROR_W-1:0]     mirror_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [PW-1:0]           parts_eff;
  logic [VID_W-1:0]        in_lo;
  logic [VID_W-1:0]        in_hi;
  logic [HASH_W-1:0]       hash;
  logic                    accept;
  logic                    mod_start;
  logic                    mod_done;
  logic [BW-1:0]           mod_rem;
  logic                    out_free;
  logic                    out_load;

  logic [MAX_PARTITIONS-1:0] pres_mem [VERTEX_COUNT];
  logic                    pres_we;
  logic [AW-1:0]           pres_waddr;
  logic [MAX_PARTITIONS-1:0] pres_wdata;
  logic                    pres_re;
  logic [AW-1:0]           pres_raddr;
  logic [MAX_PARTITIONS-1:0] pres_rdata_r;

  cnt_ctl_t                cnt_ctl;
  logic [BW-1:0]           cnt_raddr;
  logic [COUNT_WIDTH-1:0]  cnt_rd_edges;
  logic [MW-1:0]           cnt_rd_marks;
  logic [COUNT_WIDTH-1:0]  cnt_wr_edges;
  logic [MW-1:0]           cnt_wr_marks;

  logic                    lo_ok;
  logic                    hi_ok;
  logic [MAX_PARTITIONS-1:0] bkt_bit;
  logic [MAX_PARTITIONS-1:0] hi_mask;
  logic                    lo_new;
  logic                    hi_new;
  logic [SW-1:0]           mirror_sum;
  logic [LW-1:0]           largest_ext;

  // Partition count zero acts as one; above the maximum it saturates.
  always_comb begin
    if (cfg_r == '0) begin
      parts_eff = PW'(1);
    end else if (int'(cfg_r) > MAX_PARTITIONS) begin
      parts_eff = PW'(MAX_PARTITIONS);
    end else begin
      parts_eff = PW'(cfg_r);
    end
  end

  // Order the endpoints, smaller id first, and form the hash word.
  assign in_lo = (in_data.first_vertex <= in_data.second_vertex) ?
                 in_data.first_vertex : in_data.second_vertex;
  assign in_hi = (in_data.first_vertex <= in_data.second_vertex) ?
                 in_data.second_vertex : in_data.first_vertex;
  assign hash  = HASH_W'(in_lo) ^ {in_hi, 1'b0};

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign mod_start = accept && (in_data.opcode == OP_EDGE);
  assign out_free  = !out_valid_r || !out_stall;
  // load the output register at the final step of an item
  assign out_load  = out_free && ((state_r == S_HI) || (state_r == S_RDONE));

  hep_mod_unit #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (hash),
    .divisor  (parts_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  hep_count_store #(
    .DEPTH (MAX_PARTITIONS),
    .CW    (COUNT_WIDTH),
    .MW    (MW)
  ) u_cnt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cnt_ctl),
    .rd_addr  (cnt_raddr),
    .wr_addr  (bkt_r),
    .wr_edges (cnt_wr_edges),
    .wr_marks (cnt_wr_marks),
    .rd_edges (cnt_rd_edges),
    .rd_marks (cnt_rd_marks)
  );

  // Endpoints beyond the vertex range are counted but never marked.
  assign lo_ok   = int'(lo_r) < VERTEX_COUNT;
  assign hi_ok   = int'(hi_r) < VERTEX_COUNT;
  assign bkt_bit = MAX_PARTITIONS'(1) << bkt_r;

  // When both endpoints are the same vertex the hi read raced the lo write,
  // so forward the mask just written for lo.
  assign hi_mask = (hi_r == lo_r) ? lo_mask_r : pres_rdata_r;
  assign lo_new  = lo_ok && !pres_rdata_r[bkt_r];
  assign hi_new  = hi_ok && !hi_mask[bkt_r];

  // Saturating edge count; marks cannot pass the vertex count.
  assign cnt_wr_edges = (cnt_rd_edges == '1) ? cnt_rd_edges :
                        cnt_rd_edges + COUNT_WIDTH'(1);
  assign cnt_wr_marks = cnt_rd_marks + MW'(lo_new_r) + MW'(hi_new);

  assign mirror_sum  = SW'(mirror_r) + SW'(cnt_rd_marks);
  assign largest_ext = LW'(largest_r);

  // Memory port control for each step of the sequence.
  always_comb begin
    pres_we    = 1'b0;
    pres_waddr = clr_r;
    pres_wdata = '0;
    pres_re    = 1'b0;
    pres_raddr = AW'(lo_r);
    cnt_ctl    = '{rd_en: 1'b0, wr_en: 1'b0};
    cnt_raddr  = mod_rem;
    unique case (state_r)
      S_CLEAR: begin
        pres_we = 1'b1;
      end
      S_MOD: begin
        if (mod_done) begin
          pres_re       = 1'b1;
          cnt_ctl.rd_en = 1'b1;
        end
      end
      S_LO: begin
        pres_re    = 1'b1;
        pres_raddr = AW'(hi_r);
        if (lo_new) begin
          pres_we    = 1'b1;
          pres_waddr = AW'(lo_r);
          pres_wdata = pres_rdata_r | bkt_bit;
        end
      end
      S_HI: begin
        // hold every write until the output register can take the result
        if (out_free) begin
          cnt_ctl.wr_en = 1'b1;
          if (hi_new) begin
            pres_we    = 1'b1;
            pres_waddr = AW'(hi_r);
            pres_wdata = hi_mask | bkt_bit;
          end
        end
      end
      S_RPT: begin
        cnt_ctl.rd_en = 1'b1;
        cnt_raddr     = idx_r;
      end
      default: ;
    endcase
  end

  // Presence memory: one write and one registered read a cycle. The read
  // register holds when no read is issued, so a stalled step keeps its data.
  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_waddr] <= pres_wdata;
    end
    if (pres_re) begin
      pres_rdata_r <= pres_mem[pres_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_r       <= PART_RESET;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(VERTEX_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_data.opcode == OP_REPORT) begin
              idx_r     <= '0;
              pend_r    <= 1'b0;
              largest_r <= '0;
              mirror_r  <= '0;
              state_r   <= S_RPT;
            end else begin
              lo_r    <= in_lo;
              hi_r    <= in_hi;
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bkt_r   <= mod_rem;
            state_r <= S_LO;
          end
        end
        S_LO: begin
          lo_new_r  <= lo_new;
          lo_mask_r <= lo_new ? (pres_rdata_r | bkt_bit) : pres_rdata_r;
          state_r   <= S_HI;
        end
        S_HI: begin
          if (out_free) begin
            out_data_r  <= '{bucket: BUCKET_W'(bkt_r), largest_bucket_edges: '0,
                             mirror_total: '0, is_report: 1'b0};
            state_r     <= S_IDLE;
          end
        end
        S_RPT: begin
          // fold in the count read last cycle, issue the next
          if (pend_r) begin
            if (cnt_rd_edges > largest_r) begin
              largest_r <= cnt_rd_edges;
            end
            mirror_r <= (mirror_sum > SW'(MIRROR_MAX)) ? MIRROR_MAX :
                        MIRROR_W'(mirror_sum);
          end
          pend_r <= 1'b1;
          if (PW'(idx_r) == parts_eff - PW'(1)) begin
            state_r <= S_RLAST;
          end else begin
            idx_r <= idx_r + BW'(1);
          end
        end
        S_RLAST: begin
          if (cnt_rd_edges > largest_r) begin
            largest_r <= cnt_rd_edges;
          end
          mirror_r <= (mirror_sum > SW'(MIRROR_MAX)) ? MIRROR_MAX :
                      MIRROR_W'(mirror_sum);
          state_r  <= S_RDONE;
        end
        S_RDONE: begin
          if (out_free) begin
            out_data_r  <= '{bucket: '0,
                             largest_bucket_edges:
                               (largest_ext > LW'(OUT_EDGE_MAX)) ? OUT_EDGE_MAX :
                               largest_ext[OUT_EDGE_W-1:0],
                             mirror_total: mirror_r, is_report: 1'b1};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: sv/hep_checker.sv
`default_nettype none
`include "hash_edge_partitioner_unit_defines.svh"

module hep_checker import hep_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire in_item_t              in_data,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire out_item_t             out_data
);

  // a held result keeps its value
  `HEP_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "out payload changed while stalled")

  // a stalled input transfer keeps its value
  `HEP_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_data), "in payload changed while stalled")

  // edge results carry no report totals
  `HEP_ASSERT(a_edge_zero, clk, rst_n, out_valid && !out_data.is_report |-> out_data.largest_bucket_edges == 0 && out_data.mirror_total == 0, "edge result with nonzero totals")

  // report results carry bucket zero
  `HEP_ASSERT(a_rpt_bucket, clk, rst_n, out_valid && out_data.is_report |-> out_data.bucket == 0, "report result with nonzero bucket")

  // the clearing pass blocks input right after reset
  `HEP_ASSERT_ALWAYS(a_clear_stall, clk, !rst_n |=> in_stall && !out_valid, "input open or output valid after reset")

endmodule

bind hash_edge_partitioner_unit hep_checker u_hep_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_data     (in_data),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_data    (out_data)
);

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;
  import hep_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 8;
  // Random edges and reports after the directed rows.
  localparam int RANDOM_ITEMS = 1350;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_OFF_CYCLES = 400;
  // Worst item is a report over 16 buckets.
  localparam int SETTLE_CYCLES = 30;
  // Clearing pass plus the slowest legal run, with a wide margin.
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int REPORT_LIMIT = 10;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_ITEM_TYPED,
    ROW_PARTITIONS
  } row_kind_t;

  typedef struct {
    row_kind_t               kind;
    in_item_t                item;
    logic [PART_CFG_W-1:0]   parts;
    out_item_t               want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_wr_en;
  logic [PART_CFG_W-1:0] cfg_wr_data;

  // Mirror of the block's state, updated as each transfer is accepted.
  logic [PART_CFG_W-1:0]         parts_cfg = PART_RESET;
  logic [MAX_PARTITIONS_DEF-1:0] vertex_marks [VERTEX_COUNT_DEF];
  logic [OUT_EDGE_W-1:0]         bucket_edges [MAX_PARTITIONS_DEF];
  int unsigned                   bucket_marks [MAX_PARTITIONS_DEF];

  out_item_t   awaited_results[$];
  int unsigned mismatch_count = 0;

  // Sender and receiver pacing controls, set by the stimulus process.
  bit quiet_sender  = 1'b0;
  bit burst_phase   = 1'b0;
  bit hold_off_req  = 1'b0;

  stim_row_t directed_rows[$];

  hash_edge_partitioner_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Clamp the partition register the way the block does: zero acts as one,
  // anything past the bucket count acts as the bucket count.
  function automatic int unsigned active_parts();
    if (parts_cfg == 0) return 1;
    if (parts_cfg > MAX_PARTITIONS_DEF) return MAX_PARTITIONS_DEF;
    return parts_cfg;
  endfunction

  // Work out the result of one item and advance the mirrored state.
  function automatic out_item_t predict_partition(in_item_t it);
    logic [VID_W-1:0]  lo;
    logic [VID_W-1:0]  hi;
    logic [VID_W-1:0]  ends [2];
    logic [HASH_W-1:0] key;
    int unsigned       parts;
    int unsigned       b;
    logic [OUT_EDGE_W-1:0] largest;
    int unsigned       mirrors;
    out_item_t         r;
    r = '0;
    parts = active_parts();
    if (it.opcode == OP_EDGE) begin
      // Order the endpoints: smaller id first.
      lo = (it.first_vertex <= it.second_vertex) ? it.first_vertex : it.second_vertex;
      hi = (it.first_vertex <= it.second_vertex) ? it.second_vertex : it.first_vertex;
      key = {1'b0, lo} ^ ({1'b0, hi} << 1);
      b = key % parts;
      // Saturate the per-bucket edge count.
      if (bucket_edges[b] != '1) bucket_edges[b] = bucket_edges[b] + 1'b1;
      ends[0] = lo;
      ends[1] = hi;
      for (int k = 0; k < 2; k++) begin
        if (!vertex_marks[ends[k]][b]) begin
          vertex_marks[ends[k]][b] = 1'b1;
          bucket_marks[b]++;
        end
      end
      r.bucket = b[BUCKET_W-1:0];
    end else begin
      // Report covers only the buckets in use; the rest keep their state.
      largest = '0;
      mirrors = 0;
      for (int i = 0; i < parts; i++) begin
        if (bucket_edges[i] > largest) largest = bucket_edges[i];
        mirrors += bucket_marks[i];
      end
      r.largest_bucket_edges = largest;
      r.mirror_total = (mirrors > MIRROR_MAX) ? MIRROR_MAX : mirrors[MIRROR_W-1:0];
      r.is_report = 1'b1;
    end
    return r;
  endfunction

  function automatic in_item_t make_item(opcode_t op, logic [VID_W-1:0] a,
                                         logic [VID_W-1:0] c);
    in_item_t it;
    it.opcode = op;
    it.first_vertex = a;
    it.second_vertex = c;
    return it;
  endfunction

  function automatic out_item_t make_result(logic [BUCKET_W-1:0] b,
                                            logic [OUT_EDGE_W-1:0] largest,
                                            logic [MIRROR_W-1:0] mirrors, logic rep);
    out_item_t r;
    r.bucket = b;
    r.largest_bucket_edges = largest;
    r.mirror_total = mirrors;
    r.is_report = rep;
    return r;
  endfunction

  function automatic stim_row_t item_row(opcode_t op, logic [VID_W-1:0] a,
                                         logic [VID_W-1:0] c);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.item = make_item(op, a, c);
    row.parts = '0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(opcode_t op, logic [VID_W-1:0] a,
                                          logic [VID_W-1:0] c, out_item_t want);
    stim_row_t row;
    row = item_row(op, a, c);
    row.kind = ROW_ITEM_TYPED;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t parts_row(logic [PART_CFG_W-1:0] p);
    stim_row_t row;
    row = item_row(OP_EDGE, '0, '0);
    row.kind = ROW_PARTITIONS;
    row.parts = p;
    return row;
  endfunction

  // Mostly short gaps, a few long ones; none in quiet or burst phases.
  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (quiet_sender || burst_phase) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Bias vertex ids toward a small pool so marks repeat, and toward extremes.
  function automatic logic [VID_W-1:0] pick_vertex();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return VID_W'($urandom_range(0, 31));
    if (pick == 4) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (pick == 5) return VID_W'($urandom_range(65500, 65535));
    return VID_W'($urandom_range(0, 65535));
  endfunction

  // Offer one item, hold it until the transfer, then queue its expected result.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int unsigned gap;
    out_item_t   pred;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = predict_partition(it);
    awaited_results.push_back(typed ? want : pred);
  endtask

  // Let the block go idle, then write the partition register.
  task automatic write_partitions(logic [PART_CFG_W-1:0] p);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    parts_cfg = p;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    bit        bad;
    if (awaited_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("unexpected result: bucket %0d largest %0d mirrors %0d report %0b",
                 got.bucket, got.largest_bucket_edges, got.mirror_total, got.is_report);
      return;
    end
    want = awaited_results.pop_front();
    bad = (got.bucket !== want.bucket) ||
          (got.largest_bucket_edges !== want.largest_bucket_edges) ||
          (got.mirror_total !== want.mirror_total) ||
          (got.is_report !== want.is_report);
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("result mismatch: exp bucket %0d largest %0d mirrors %0d report %0b",
                 want.bucket, want.largest_bucket_edges, want.mirror_total,
                 want.is_report);
        $display("                 got bucket %0d largest %0d mirrors %0d report %0b",
                 got.bucket, got.largest_bucket_edges, got.mirror_total, got.is_report);
      end
    end
  endtask

  // Result side: check each transfer, then pick the stall for the next cycle.
  initial begin : result_sink
    int unsigned run_left;
    int unsigned calm_left;
    int unsigned pick;
    run_left  = 0;
    calm_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) check_result(out_data);
      // Take up a long hold-off request: count it down right here.
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        run_left  = HOLD_OFF_CYCLES;
        calm_left = 0;
      end
      if (run_left > 0) begin
        out_stall <= 1'b1;
        run_left--;
      end else if (calm_left > 0) begin
        out_stall <= 1'b0;
        calm_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_stall <= 1'b0;
        end else if (pick < 85) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(0, 3);
        end else if (pick < 95) begin
          // Stretch with no stalls at all.
          out_stall <= 1'b0;
          calm_left = $urandom_range(20, 80);
        end else begin
          out_stall <= 1'b1;
          run_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain, verdict.
  initial begin : stimulus
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       phase_len;
    int unsigned       pick;
    logic [PART_CFG_W-1:0] p;
    opcode_t           op;

    foreach (vertex_marks[v]) vertex_marks[v] = '0;
    foreach (bucket_edges[i]) begin
      bucket_edges[i] = '0;
      bucket_marks[i] = 0;
    end

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;

    // Empty report after reset, the extreme ids, endpoint ordering both ways,
    // the clamped partition counts, and buckets left out of a report.
    directed_rows.push_back(typed_row(OP_REPORT, 16'h0000, 16'h0000,
                                      make_result(4'd0, 32'd0, 21'd0, 1'b1)));
    directed_rows.push_back(typed_row(OP_EDGE, 16'h0000, 16'h0000,
                                      make_result(4'd0, 32'd0, 21'd0, 1'b0)));
    directed_rows.push_back(item_row(OP_EDGE, 16'hFFFF, 16'hFFFF));
    directed_rows.push_back(item_row(OP_EDGE, 16'hFFFF, 16'h0000));
    directed_rows.push_back(item_row(OP_EDGE, 16'h0000, 16'hFFFF));
    directed_rows.push_back(item_row(OP_EDGE, 16'h0002, 16'h0001));
    directed_rows.push_back(item_row(OP_EDGE, 16'h0001, 16'h0002));
    directed_rows.push_back(item_row(OP_REPORT, 16'h0000, 16'h0000));
    directed_rows.push_back(parts_row(5'd1));
    directed_rows.push_back(typed_row(OP_EDGE, 16'h1234, 16'hFEDC,
                                      make_result(4'd0, 32'd0, 21'd0, 1'b0)));
    directed_rows.push_back(item_row(OP_REPORT, 16'h0000, 16'h0000));
    directed_rows.push_back(parts_row(5'd0));
    directed_rows.push_back(typed_row(OP_EDGE, 16'hAAAA, 16'h5555,
                                      make_result(4'd0, 32'd0, 21'd0, 1'b0)));
    directed_rows.push_back(item_row(OP_REPORT, 16'h0000, 16'h0000));
    directed_rows.push_back(parts_row(5'd16));
    directed_rows.push_back(item_row(OP_EDGE, 16'hAAAA, 16'h5555));
    directed_rows.push_back(item_row(OP_EDGE, 16'h5555, 16'hAAAA));
    directed_rows.push_back(item_row(OP_EDGE, 16'h8000, 16'h7FFF));
    directed_rows.push_back(item_row(OP_REPORT, 16'h0000, 16'h0000));
    directed_rows.push_back(parts_row(5'd31));
    directed_rows.push_back(item_row(OP_EDGE, 16'h00FF, 16'hFF00));
    directed_rows.push_back(item_row(OP_REPORT, 16'h0000, 16'h0000));
    directed_rows.push_back(parts_row(5'd17));
    directed_rows.push_back(item_row(OP_REPORT, 16'hFFFF, 16'hFFFF));
    directed_rows.push_back(parts_row(5'd2));
    directed_rows.push_back(item_row(OP_REPORT, 16'hFFFF, 16'h0000));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; in_stall holds off the first transfer
    // until the clearing pass is done.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_PARTITIONS)
        write_partitions(directed_rows[r].parts);
      else
        send_item(directed_rows[r].item, directed_rows[r].kind == ROW_ITEM_TYPED,
                  directed_rows[r].want);
    end

    // Random phases, each under a fresh partition count.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: p = 5'd0;
        1: p = 5'd16;
        2: p = 5'd31;
        3: p = 5'd1;
        default: p = PART_CFG_W'($urandom_range(0, 31));
      endcase
      write_partitions(p);
      phase_len    = $urandom_range(60, 200);
      quiet_sender = ($urandom_range(0, 3) == 0);
      // In one phase, stop the receiver for a long stretch and keep
      // offering back to back so the block fills and stalls its input.
      burst_phase  = (phase == 2);
      if (burst_phase) hold_off_req = 1'b1;
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        op = ($urandom_range(0, 99) < 7) ? OP_REPORT : OP_EDGE;
        send_item(make_item(op, pick_vertex(), pick_vertex()), 1'b0, '0);
        sent++;
      end
      burst_phase = 1'b0;
      phase++;
    end

    // Drain: wait for every expected result, then let the pipe settle.
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
